FILE: design/rrmu_pkg.sv
// shared types, constants and sample conversion for the running mean update unit
package rrmu_pkg;

   localparam int MEAN_W    = 16;
   localparam int SAMPLE_W  = 32;
   localparam int COUNT_W   = 31;
   localparam int MAG_W     = 16;
   localparam int DELTA_W   = MEAN_W + 2;
   localparam int STAGES    = MAG_W + 2;
   localparam int FRAC_DROP = 10;
   localparam int HALF_LSB  = 512;
   localparam logic [MEAN_W-1:0] Q_MAX = 16'hFFFF;

   typedef struct packed {
      logic [STAGES-1:0] load;
   } rrmu_ctrl_type;

   // signed q16.16 to unsigned q10.6, round half up, saturate
   function automatic logic [MEAN_W-1:0] to_q10_6(input logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W:0]           sum;
      logic [SAMPLE_W-FRAC_DROP:0] q;
      logic [MEAN_W-1:0]           res;
      sum = {1'b0, s} + (SAMPLE_W+1)'(HALF_LSB);
      q   = sum[SAMPLE_W:FRAC_DROP];
      if (s[SAMPLE_W-1] || s == '0) begin
         res = '0;
      end else if (q > (SAMPLE_W-FRAC_DROP+1)'(Q_MAX)) begin
         res = Q_MAX;
      end else begin
         res = q[MEAN_W-1:0];
      end
      return res;
   endfunction

endpackage

FILE: design/rgb_running_mean_update_unit.sv
// top level: three channel lanes under one pipeline control, results merged into one transfer
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------------------
//   req_    | in  | tdata: means r,g,b (16 each), samples r,g,b (32 each), count (31)
//   rsp_    | out | tdata: new means r,g,b (16 each)
//
// one item per cycle sustained while rsp_tready stays high
// the divider has 16 stages, one quotient bit per stage
// reset clears the stage valid bits only; no payload state
// a stalled output lets earlier stages keep filling; req_tready falls only
// when every stage holds an item and rsp_tready is low
module rgb_running_mean_update_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [15:0] mean_red, [31:16] mean_green, [47:32] mean_blue,
   // [79:48] sample_red, [111:80] sample_green, [143:112] sample_blue,
   // [174:144] sample_count, [175] zero
   input  logic [175:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [15:0] new_mean_red, [31:16] new_mean_green, [47:32] new_mean_blue
   output logic [47:0]  rsp_tdata
);

   localparam int MW = rrmu_pkg::MEAN_W;
   localparam int SW = rrmu_pkg::SAMPLE_W;
   localparam int NW = rrmu_pkg::COUNT_W;
   localparam int SBASE = 3 * MW;
   localparam int NBASE = 3 * MW + 3 * SW;

   rrmu_pkg::rrmu_ctrl_type ctrl;
   logic [MW-1:0]           lane_mean [0:2];

   rrmu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .ctrl      (ctrl)
   );

   for (genvar c = 0; c < 3; c++) begin : g_lane
      rrmu_lane u_lane (
         .clock    (clock),
         .ctrl     (ctrl),
         .mean     (req_tdata[c*MW +: MW]),
         .sample   (req_tdata[SBASE + c*SW +: SW]),
         .count    (req_tdata[NBASE +: NW]),
         .new_mean (lane_mean[c])
      );
   end

   assign rsp_tdata = {lane_mean[2], lane_mean[1], lane_mean[0]};

endmodule

FILE: design/rrmu_ctrl.sv
// stage valid bits and per-stage load enables for the lane pipelines
module rrmu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rrmu_pkg::rrmu_ctrl_type ctrl
);

   localparam int S = rrmu_pkg::STAGES;

   logic [S-1:0] valid_ff;
   logic [S-1:0] valid_in;
   logic [S-1:0] space;

   // a stage may load when the output drains or any stage from it onward is empty
   always_comb begin
      for (int k = 0; k < S; k++) begin
         space[k] = out_ready || !(&(valid_ff | ((S'(1) << k) - S'(1))));
      end
   end

   always_comb begin
      valid_in = valid_ff;
      for (int k = 0; k < S; k++) begin
         if (space[k]) begin
            valid_in[k] = (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = space;
   assign in_ready  = space[0];
   assign out_valid = valid_ff[S-1];

   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> &valid_ff) else $error("input stalled with an empty stage");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0]) else $error("accepted transfer lost at entry");

   a_item_moves_on: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && space[1] |=> valid_ff[1]) else $error("item dropped between stages");

   a_output_kept: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid) else $error("stalled result dropped");

endmodule

FILE: design/rrmu_lane.sv
// one color channel: sample conversion, pipelined restoring divide, final add and clamp
module rrmu_lane (
   input  logic                                clock,
   input  rrmu_pkg::rrmu_ctrl_type             ctrl,
   input  logic [rrmu_pkg::MEAN_W-1:0]         mean,
   input  logic [rrmu_pkg::SAMPLE_W-1:0]       sample,
   input  logic [rrmu_pkg::COUNT_W-1:0]        count,
   output logic [rrmu_pkg::MEAN_W-1:0]         new_mean
);

   localparam int MW = rrmu_pkg::MEAN_W;
   localparam int NW = rrmu_pkg::COUNT_W;
   localparam int QW = rrmu_pkg::MAG_W;
   localparam int DW = rrmu_pkg::DELTA_W;

   logic          neg_ff  [0:QW];
   logic [MW-1:0] mean_ff [0:QW];
   logic [NW-1:0] div_ff  [0:QW];
   logic [NW-1:0] rem_ff  [0:QW];
   logic [QW-1:0] aq_ff   [0:QW];
   logic [MW-1:0] new_mean_ff;

   logic [MW-1:0] q_in;
   logic [DW-1:0] delta_in;
   logic [DW-1:0] mag_in;
   logic [DW-1:0] step_in;
   logic [DW-1:0] sum_in;
   logic [MW-1:0] new_mean_in;

   // entry: convert sample, signed delta, magnitude and divisor
   always_comb begin
      q_in     = rrmu_pkg::to_q10_6(sample);
      delta_in = {2'b00, q_in} - {2'b00, mean};
      mag_in   = delta_in[DW-1] ? (DW'(0) - delta_in) : delta_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         neg_ff[0]  <= delta_in[DW-1];
         mean_ff[0] <= mean;
         // a zero count takes the whole delta, same as dividing by one
         div_ff[0]  <= (count == '0) ? NW'(1) : count;
         rem_ff[0]  <= '0;
         aq_ff[0]   <= mag_in[QW-1:0];
      end
   end

   // one quotient bit per stage; dividend bits shift out as quotient bits shift in
   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [NW:0]   trial;
      logic          ge;
      logic [NW:0]   diff;

      always_comb begin
         trial = {rem_ff[k-1], aq_ff[k-1][QW-1]};
         ge    = trial >= {1'b0, div_ff[k-1]};
         diff  = trial - {1'b0, div_ff[k-1]};
      end

      always_ff @(posedge clock) begin
         if (ctrl.load[k]) begin
            neg_ff[k]  <= neg_ff[k-1];
            mean_ff[k] <= mean_ff[k-1];
            div_ff[k]  <= div_ff[k-1];
            rem_ff[k]  <= ge ? diff[NW-1:0] : trial[NW-1:0];
            aq_ff[k]   <= {aq_ff[k-1][QW-2:0], ge};
         end
      end
   end

   always_comb begin
      step_in = neg_ff[QW] ? (DW'(0) - {2'b00, aq_ff[QW]}) : {2'b00, aq_ff[QW]};
      sum_in  = {2'b00, mean_ff[QW]} + step_in;
      if (sum_in[DW-1]) begin
         new_mean_in = '0;
      end else if (sum_in[DW-2:MW] != '0) begin
         new_mean_in = rrmu_pkg::Q_MAX;
      end else begin
         new_mean_in = sum_in[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[QW+1]) begin
         new_mean_ff <= new_mean_in;
      end
   end

   assign new_mean = new_mean_ff;

endmodule

FILE: dv/tb_rgb_running_mean_update_unit.sv
// testbench for the rgb running mean update unit: directed edge cases and random pixels
module tb_rgb_running_mean_update_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MEAN_W       = rrmu_pkg::MEAN_W;
   localparam int SAMPLE_W     = rrmu_pkg::SAMPLE_W;
   localparam int COUNT_W      = rrmu_pkg::COUNT_W;

   localparam int CHANNELS     = 3;
   localparam int RANDOM_ITEMS = 1700;
   localparam int BLOCK_ITEMS  = 100;
   localparam int MAX_IDLE     = 3;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 1000;

   typedef logic [CHANNELS-1:0][MEAN_W-1:0] rgb_mean_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                  count;
      logic [CHANNELS-1:0][SAMPLE_W-1:0]   radiance;
      rgb_mean_type                        mean;
   } pixel_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [175:0]  req_tdata  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [47:0]   rsp_tdata;

   rgb_mean_type  expected_means [$];
   bit            idle_on      = 1'b1;
   int            fail_count   = 0;
   int            rsp_hold     = 0;
   int            quiet_cycles = 0;
   int unsigned   stall;
   string         channel_name [CHANNELS] = '{"red", "green", "blue"};

   rgb_running_mean_update_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // q16.16 radiance to q10.6, round half up, zero for non-positive input, clip at full scale
   function automatic longint radiance_to_q10_6(input logic [SAMPLE_W-1:0] s);
      longint q;
      if ($signed(s) <= 0) begin
         return 0;
      end
      q = (longint'($signed(s)) + 512) >>> 10;
      if (q > 65535) begin
         q = 65535;
      end
      return q;
   endfunction

   function automatic rgb_mean_type predict_means(input pixel_type px);
      rgb_mean_type res;
      longint    m;
      longint    diff;
      longint    step;
      longint    n;
      longint    r;
      n = longint'(px.count);
      for (int c = 0; c < CHANNELS; c++) begin
         m    = longint'(px.mean[c]);
         diff = radiance_to_q10_6(px.radiance[c]) - m;
         // signed division truncates toward zero
         step = (n == 0) ? diff : diff / n;
         r    = m + step;
         if (r < 0) begin
            r = 0;
         end else if (r > 65535) begin
            r = 65535;
         end
         res[c] = r[MEAN_W-1:0];
      end
      return res;
   endfunction

   function automatic pixel_type make_pixel(input logic [MEAN_W-1:0] mr, mg, mb,
                                            input logic [SAMPLE_W-1:0] sr, sg, sb,
                                            input logic [COUNT_W-1:0] n);
      pixel_type px;
      px.mean     = {mb, mg, mr};
      px.radiance = {sb, sg, sr};
      px.count    = n;
      return px;
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int     sel;
      for (int c = 0; c < CHANNELS; c++) begin
         sel = $urandom_range(0, 99);
         if (sel < 5) begin
            px.mean[c] = '0;
         end else if (sel < 10) begin
            px.mean[c] = '1;
         end else begin
            px.mean[c] = MEAN_W'($urandom);
         end
         sel = $urandom_range(0, 99);
         if (sel < 15) begin
            px.radiance[c] = $urandom;
         end else if (sel < 25) begin
            px.radiance[c] = $urandom | 32'h8000_0000;
         end else if (sel < 30) begin
            px.radiance[c] = '0;
         end else if (sel < 35) begin
            px.radiance[c] = $urandom_range(0, 2047);
         end else begin
            // mostly the useful range, up to just past saturation
            px.radiance[c] = $urandom_range(0, 32'h0400_0200);
         end
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         px.count = '0;
      end else if (sel < 60) begin
         px.count = COUNT_W'($urandom_range(1, 64));
      end else if (sel < 80) begin
         px.count = COUNT_W'($urandom_range(1, 4096));
      end else begin
         px.count = COUNT_W'($urandom);
      end
      return px;
   endfunction

   task automatic send_pixel(input pixel_type px);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_means.push_back(predict_means(px));
   endtask

   task automatic check_means(input rgb_mean_type got);
      rgb_mean_type want;
      if (expected_means.size() == 0) begin
         $display("%0t: result with nothing pending, actual %h", $time, got);
         fail_count++;
         return;
      end
      want = expected_means.pop_front();
      for (int c = 0; c < CHANNELS; c++) begin
         if (got[c] !== want[c]) begin
            $display("%0t: new_mean_%s expected %h actual %h",
                     $time, channel_name[c], want[c], got[c]);
            fail_count++;
         end
      end
   endtask

   // result side: check each transfer, then, while idling is on, stall rsp_tready for a random time that may be zero
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_means(rsp_tdata);
         stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         rsp_hold   <= stall;
         rsp_tready <= (stall == 0);
      end else if (!rsp_tready) begin
         if (rsp_hold <= 1) begin
            rsp_tready <= 1'b1;
            rsp_hold   <= 0;
         end else begin
            rsp_hold <= rsp_hold - 1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // count zero or one: the mean is replaced by the converted sample
   task automatic test_sample_conversion();
      send_pixel(make_pixel(16'h0000, 16'hFFFF, 16'h8000,
                            32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 31'd0));
      send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF,
                            32'd511, 32'd512, 32'd1535, 31'd0));
      send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000,
                            32'd1536, 32'h03FF_FDFF, 32'h03FF_FE00, 31'd0));
      send_pixel(make_pixel(16'h0000, 16'h1234, 16'hFFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd1));
      send_pixel(make_pixel(16'h0001, 16'h7FFF, 16'hFFFE,
                            32'h0000_0001, 32'hFFFF_FC00, 32'h0001_0000, 31'd0));
   endtask

   task automatic test_count_edges();
      send_pixel(make_pixel(16'hFFFF, 16'h0000, 16'h1234,
                            32'h0000_0000, 32'h7FFF_FFFF, 32'h0100_0000, 31'd2));
      send_pixel(make_pixel(16'h0ABC, 16'hFFFF, 16'h0000,
                            32'h0012_3456, 32'h0000_0400, 32'h03FF_FFFF, 31'd1));
      // negative deltas truncate toward zero
      send_pixel(make_pixel(16'd10, 16'd11, 16'd5,
                            32'd0, 32'd1024, 32'd2048, 31'd3));
      send_pixel(make_pixel(16'h0000, 16'hFFFF, 16'h8000,
                            32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0001, 31'h7FFF_FFFF));
      send_pixel(make_pixel(16'h0000, 16'hFFFF, 16'h0000,
                            32'h7FFF_FFFF, 32'h0000_0000, 32'h03FF_FE00, 31'd65535));
      send_pixel(make_pixel(16'h0000, 16'hFFFF, 16'h4000,
                            32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 31'd65536));
      send_pixel(make_pixel(16'hAAAA, 16'h5555, 16'h0001,
                            32'h5555_5555, 32'h2AAA_AAAA, 32'h0000_0600, 31'h4000_0000));
   endtask

   // random pixels in blocks; every fourth block runs with no idling on either side
   task automatic test_random_pixels();
      for (int b = 0; b < RANDOM_ITEMS / BLOCK_ITEMS; b++) begin
         idle_on = (b % 4 != 3);
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            send_pixel(random_pixel());
         end
      end
      idle_on = 1'b1;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_means.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_sample_conversion();
      test_count_edges();
      test_random_pixels();
      drain_results();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
